FILE: hdl/shsb_pkg.sv
// ----------------------------------------------------------------------------
// shsb_pkg
// Types and constants shared by the simhash signature builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shsb_pkg;

    localparam int unsigned NUM_BITS = 32;
    localparam int unsigned HASH_W   = 31;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORDS_W  = 11;

    localparam logic [NUM_BITS-1:0] RS_STEP   = 32'd378551;
    localparam logic [NUM_BITS-1:0] RS_SEED   = 32'd63689;
    localparam logic [NUM_BITS-1:0] HASH_MASK = 32'h7FFF_FFFF;

    // Finished word on its way from the hash stage to the tally stage
    typedef struct packed {
        logic              doc_end;
        logic [HASH_W-1:0] hash;
    } fold_t;

    // Document result handed from the tally stage to the output register
    typedef struct packed {
        logic               saturated;
        logic [WORDS_W-1:0] words_seen;
        logic [HASH_W-1:0]  signature;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/simhash_signature_builder_core.sv
// ----------------------------------------------------------------------------
// simhash_signature_builder_core
// Streams text bytes, folds each word's RS hash into 32 per-bit tallies and emits
// the simhash signature and word count at the end of every document.
// ----------------------------------------------------------------------------
// Throughput: one byte transfer per cycle while input is not held back.
// A tlast transfer passes the input and fold registers into the output register.
// Input is held back only while a result waits on the output and the next
// document end has reached the tally stage.
// Reset: aresetn, synchronous; clears hash, tallies, count and all valids.
// ----------------------------------------------------------------------------
`default_nettype none

module simhash_signature_builder_core
    import shsb_pkg::*;
#(
    parameter int unsigned MAX_WORDS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tuser,   // [0] word_end
    input  wire logic        s_axis_tlast,   // doc_end
    // Document results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [30:0] signature, [41:31] words_seen,
                                             // [47:42] zero
    output logic             m_axis_tuser    // [0] tally_saturated
);

    // Input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_wend_reg;
    logic              in_dend_reg;

    // Fold register between hash and tally stages
    logic              fold_valid_reg, fold_valid_next;
    fold_t             fold_reg;
    logic [HASH_W-1:0] fold_hash;

    // Output register
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           result;

    logic s_xfer;
    logic out_free;
    logic fold_move;
    logic fold_free;
    logic in_fold;
    logic in_move;

    // Stall chain: only a document end in the tally stage can wait on the output
    assign s_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign fold_move = fold_valid_reg && (!fold_reg.doc_end || out_free);
    assign fold_free = !fold_valid_reg || fold_move;
    assign in_fold   = in_wend_reg || in_dend_reg;
    assign in_move   = in_valid_reg && (!in_fold || fold_free);

    assign s_axis_tready = !in_valid_reg || in_move;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (in_move) begin
            in_valid_next = 1'b0;
        end

        fold_valid_next = fold_valid_reg;
        if (in_move && in_fold) begin
            fold_valid_next = 1'b1;
        end else if (fold_move) begin
            fold_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fold_move && fold_reg.doc_end) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            fold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            fold_valid_reg <= fold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: load on transfer or advance, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_axis_tdata;
            in_wend_reg <= s_axis_tuser;
            in_dend_reg <= s_axis_tlast;
        end
        if (in_move && in_fold) begin
            fold_reg.doc_end <= in_dend_reg;
            fold_reg.hash    <= fold_hash;
        end
        if (fold_move && fold_reg.doc_end) begin
            out_reg <= result;
        end
    end

    shsb_hash_unit u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (in_move),
        .text_byte (in_byte_reg),
        .fold_en   (in_fold),
        .fold_hash (fold_hash)
    );

    shsb_tally_bank #(
        .MAX_WORDS (MAX_WORDS)
    ) u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (fold_move),
        .fold    (fold_reg),
        .result  (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.words_seen, out_reg.signature};
    assign m_axis_tuser  = out_reg.saturated;

    // A result appears only after a document end left the tally stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fold_move && fold_reg.doc_end))
        else $error("result without document end");

    // A blocked fold entry holds its contents
    a_fold_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fold_valid_reg && !fold_move) |=> (fold_valid_reg && $stable(fold_reg)))
        else $error("fold entry lost while stalled");

    // Input is refused only while input, fold and output registers are all full
    a_ready_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && fold_valid_reg && fold_reg.doc_end
                            && out_valid_reg))
        else $error("input stalled without cause");

endmodule

`default_nettype wire

FILE: hdl/shsb_hash_unit.sv
// ----------------------------------------------------------------------------
// shsb_hash_unit
// Running RS hash over the bytes of one word; restarts when a word is folded.
// ----------------------------------------------------------------------------
`default_nettype none

module shsb_hash_unit
    import shsb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic              fold_en,
    output logic      [HASH_W-1:0] fold_hash
);

    logic [NUM_BITS-1:0]   hash_reg, hash_next;
    logic [NUM_BITS-1:0]   mult_reg, mult_next;
    logic [2*NUM_BITS-1:0] hash_prod;
    logic [2*NUM_BITS-1:0] mult_prod;
    logic [NUM_BITS-1:0]   byte_ext;
    logic [NUM_BITS-1:0]   hash_upd;
    logic [NUM_BITS-1:0]   hash_masked;

    // Sign-extend the byte as a signed char
    assign byte_ext  = {{(NUM_BITS-BYTE_W){text_byte[BYTE_W-1]}}, text_byte};
    assign hash_prod = {{NUM_BITS{1'b0}}, hash_reg} * {{NUM_BITS{1'b0}}, mult_reg};
    assign mult_prod = {{NUM_BITS{1'b0}}, mult_reg} * {{NUM_BITS{1'b0}}, RS_STEP};

    always_comb begin
        // A zero byte leaves the hash untouched
        if (text_byte != '0) begin
            hash_upd  = hash_prod[NUM_BITS-1:0] + byte_ext;
            mult_next = mult_prod[NUM_BITS-1:0];
        end else begin
            hash_upd  = hash_reg;
            mult_next = mult_reg;
        end
        hash_next = hash_upd;
        if (fold_en) begin
            hash_next = '0;
            mult_next = RS_SEED;
        end
    end

    assign hash_masked = hash_upd & HASH_MASK;
    assign fold_hash   = hash_masked[HASH_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            mult_reg <= RS_SEED;
        end else if (advance) begin
            hash_reg <= hash_next;
            mult_reg <= mult_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/shsb_tally_bank.sv
// ----------------------------------------------------------------------------
// shsb_tally_bank
// Saturating per-bit tallies and word count; forms the document signature.
// ----------------------------------------------------------------------------
`default_nettype none

module shsb_tally_bank
    import shsb_pkg::*;
#(
    parameter int unsigned MAX_WORDS = 1024
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    advance,
    input  wire fold_t   fold,
    output result_t      result
);

    localparam int unsigned CW = $clog2(MAX_WORDS + 1);
    localparam int unsigned TW = CW + 1;
    localparam logic signed [TW-1:0] TALLY_MAX = signed'(TW'(MAX_WORDS));
    localparam logic signed [TW-1:0] TALLY_MIN = -TALLY_MAX;
    localparam logic [CW-1:0]        COUNT_MAX = CW'(MAX_WORDS);

    logic signed [TW-1:0] tally_reg  [NUM_BITS];
    logic signed [TW-1:0] tally_next [NUM_BITS];
    logic [CW-1:0]        count_reg, count_next;
    logic                 sat_reg, sat_next;
    logic [NUM_BITS-1:0]  word_bits;
    logic [CW+WORDS_W-1:0] count_wide;
    logic [NUM_BITS-1:0]  sign_bits;

    assign word_bits = {{(NUM_BITS-HASH_W){1'b0}}, fold.hash};

    always_comb begin
        sat_next = sat_reg;
        for (int i = 0; i < NUM_BITS; i++) begin
            tally_next[i] = tally_reg[i];
            if (word_bits[i]) begin
                if (tally_reg[i] >= TALLY_MAX) begin
                    sat_next = 1'b1;
                end else begin
                    tally_next[i] = tally_reg[i] + TW'(1);
                end
            end else begin
                if (tally_reg[i] <= TALLY_MIN) begin
                    sat_next = 1'b1;
                end else begin
                    tally_next[i] = tally_reg[i] - TW'(1);
                end
            end
        end
        count_next = count_reg;
        if (count_reg >= COUNT_MAX) begin
            sat_next = 1'b1;
        end else begin
            count_next = count_reg + CW'(1);
        end
    end

    // Bit set where the tally ends up strictly positive
    always_comb begin
        for (int i = 0; i < NUM_BITS; i++) begin
            sign_bits[i] = !tally_next[i][TW-1] && (tally_next[i] != '0);
        end
    end

    assign count_wide        = {{WORDS_W{1'b0}}, count_next};
    assign result.signature  = sign_bits[HASH_W-1:0];
    assign result.words_seen = count_wide[WORDS_W-1:0];
    assign result.saturated  = sat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BITS; i++) begin
                tally_reg[i] <= '0;
            end
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end else if (advance) begin
            if (fold.doc_end) begin
                for (int i = 0; i < NUM_BITS; i++) begin
                    tally_reg[i] <= '0;
                end
                count_reg <= '0;
                sat_reg   <= 1'b0;
            end else begin
                for (int i = 0; i < NUM_BITS; i++) begin
                    tally_reg[i] <= tally_next[i];
                end
                count_reg <= count_next;
                sat_reg   <= sat_next;
            end
        end
    end

    // Top tally only ever sees a clear bit, so it never goes positive
    a_top_tally_nonpos: assert property (@(posedge aclk) disable iff (!aresetn)
        (tally_reg[NUM_BITS-1][TW-1] || (tally_reg[NUM_BITS-1] == '0)))
        else $error("top tally went positive");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("word count beyond limit");

    a_tally_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (tally_reg[0] <= TALLY_MAX) && (tally_reg[0] >= TALLY_MIN))
        else $error("bit tally beyond limit");

endmodule

`default_nettype wire
